### src/cse_pkg.sv
// ----------------------------------------------------------------------------
// Counting sort engine package
// Shared widths, constants, the result record and the bin index mapping.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int VALUE_BITS = 8;
  localparam int MAX_ITEMS  = 64;
  localparam int NUM_BINS   = 1 << VALUE_BITS;
  localparam int BIN_BITS   = VALUE_BITS;
  localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

  localparam logic [CNT_BITS-1:0]   MAX_CNT  = CNT_BITS'(MAX_ITEMS);
  localparam logic [VALUE_BITS-1:0] MIN_INIT = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] MAX_INIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  overflow;
  } emit_t;

  // Flipping the sign bit makes ascending bin order equal ascending signed order.
  // The mapping is its own inverse.
  function automatic logic [BIN_BITS-1:0] bin_of(input logic [VALUE_BITS-1:0] v);
    return {~v[VALUE_BITS-1], v[VALUE_BITS-2:0]};
  endfunction

endpackage

### src/cse_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/cse_out_reg.sv
// ----------------------------------------------------------------------------
// Counting sort output register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module cse_out_reg
  import cse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  emit_t                 emit_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] sorted_value_o,
  output logic                  last_out_o,
  output logic                  overflow_o
);

  logic                  valid_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  last_q;
  logic                  ovf_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= emit_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && emit_i.valid) begin
      value_q <= emit_i.value;
      last_q  <= emit_i.last;
      ovf_q   <= emit_i.overflow;
    end
  end

  assign out_valid_o    = valid_q;
  assign sorted_value_o = value_q;
  assign last_out_o     = last_q;
  assign overflow_o     = ovf_q;

endmodule

### src/cse_ctrl.sv
// ----------------------------------------------------------------------------
// Counting sort controller
// Clears the count store, increments bins on load and scans them on drain.
// ----------------------------------------------------------------------------
module cse_ctrl
  import cse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  output logic                  in_stall_o,
  input  logic                  emit_ready_i,
  output emit_t                 emit_o,
  output logic                  ram_we_o,
  output logic [BIN_BITS-1:0]   ram_waddr_o,
  output logic [CNT_BITS-1:0]   ram_wdata_o,
  output logic [BIN_BITS-1:0]   ram_raddr_o,
  input  logic [CNT_BITS-1:0]   ram_rdata_i
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [BIN_BITS-1:0]   clr_q;
  logic [VALUE_BITS-1:0] min_q, max_q;
  logic [CNT_BITS-1:0]   items_q;
  logic                  drop_q;
  logic                  load_q;
  logic                  last_q;
  logic [BIN_BITS-1:0]   bin_q;
  logic [BIN_BITS-1:0]   scan_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [CNT_BITS-1:0]   remain_q;

  logic accept;
  logic can_load;
  logic fire;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign can_load = (items_q != MAX_CNT);
  assign fire     = (state_q == S_EMIT) && emit_ready_i;

  assign in_stall_o = (state_q != S_IDLE);

  assign emit_o.valid    = (state_q == S_EMIT);
  assign emit_o.value    = bin_of(scan_q);
  assign emit_o.last     = (remain_q == CNT_BITS'(1));
  assign emit_o.overflow = drop_q;

  // The count store is read at the accept edge, so the incremented count is
  // written back in the next cycle while further transfers are held off.
  assign ram_raddr_o = (state_q == S_IDLE) ? bin_of(value_i) : scan_q;

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = scan_q;
    ram_wdata_o = '0;
    case (state_q)
      S_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
      end
      S_WR: begin
        ram_we_o    = load_q;
        ram_waddr_o = bin_q;
        ram_wdata_o = ram_rdata_i + CNT_BITS'(1);
      end
      S_CHK: begin
        ram_we_o = 1'b1;
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == {BIN_BITS{1'b1}}) state_d = S_IDLE;
      S_IDLE: if (accept) state_d = S_WR;
      S_WR:   state_d = last_q ? S_RD : S_IDLE;
      S_RD:   state_d = S_CHK;
      S_CHK:  state_d = (ram_rdata_i == '0) ? S_RD : S_EMIT;
      S_EMIT: begin
        if (fire) begin
          if (remain_q == CNT_BITS'(1)) begin
            state_d = S_IDLE;
          end else if (cnt_q == CNT_BITS'(1)) begin
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      min_q    <= MIN_INIT;
      max_q    <= MAX_INIT;
      items_q  <= '0;
      drop_q   <= 1'b0;
      load_q   <= 1'b0;
      last_q   <= 1'b0;
      bin_q    <= '0;
      scan_q   <= '0;
      cnt_q    <= '0;
      remain_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + BIN_BITS'(1);
        end
        S_IDLE: begin
          if (accept) begin
            load_q <= can_load;
            last_q <= last_i;
            bin_q  <= bin_of(value_i);
            if (can_load) begin
              items_q <= items_q + CNT_BITS'(1);
              if ($signed(value_i) < $signed(min_q)) min_q <= value_i;
              if ($signed(value_i) > $signed(max_q)) max_q <= value_i;
            end else begin
              drop_q <= 1'b1;
            end
          end
        end
        S_WR: begin
          scan_q   <= bin_of(min_q);
          remain_q <= items_q;
        end
        S_CHK: begin
          // The bin is emptied as it is read; a zero bin simply moves on.
          cnt_q <= ram_rdata_i;
          if (ram_rdata_i == '0) scan_q <= scan_q + BIN_BITS'(1);
        end
        S_EMIT: begin
          if (fire) begin
            cnt_q    <= cnt_q - CNT_BITS'(1);
            remain_q <= remain_q - CNT_BITS'(1);
            if (remain_q == CNT_BITS'(1)) begin
              min_q   <= MIN_INIT;
              max_q   <= MAX_INIT;
              items_q <= '0;
              drop_q  <= 1'b0;
            end else if (cnt_q == CNT_BITS'(1)) begin
              scan_q <= scan_q + BIN_BITS'(1);
            end
          end
        end
        default: begin
          clr_q <= clr_q;
        end
      endcase
    end
  end

  a_no_emit_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !emit_o.valid)
    else $error("result offered during the clearing pass");

  a_emit_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (cnt_q != '0) && (cnt_q <= remain_q))
    else $error("bin count exceeds remaining results");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_CHK || state_q == S_EMIT)
      |-> (scan_q <= bin_of(max_q)))
    else $error("drain scan passed the largest loaded value");

  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit_o.last) |=> (state_q == S_IDLE) && (items_q == '0))
    else $error("drain did not finish after the final result");

endmodule

### src/counting_sort_engine.sv
// ----------------------------------------------------------------------------
// Counting sort engine
// Counts signed values in a bin store and emits them in ascending order.
// ----------------------------------------------------------------------------
// After reset the block clears its 256-entry count store, one bin per cycle,
// and holds in_stall_o high until the clear is done. For each loaded value the
// block reads its bin from the count store and then writes back the
// incremented count, holding in_stall_o high for the write. On a value marked
// last, the drain walks the bins from the smallest to the largest loaded value,
// reading each bin visited, then checking and clearing it, and emits one result
// per stored count, the bins being read one at a time through the single read
// port of the count store. Up to 64 values are kept per set; further values are
// dropped and every result of that set carries overflow.
// ----------------------------------------------------------------------------
module counting_sort_engine
  import cse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] sorted_value_o,
  output logic                  last_out_o,
  output logic                  overflow_o
);

  emit_t               emit;
  logic                emit_ready;
  logic                ram_we;
  logic [BIN_BITS-1:0] ram_waddr;
  logic [CNT_BITS-1:0] ram_wdata;
  logic [BIN_BITS-1:0] ram_raddr;
  logic [CNT_BITS-1:0] ram_rdata;

  cse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .value_i     (value_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .emit_ready_i(emit_ready),
    .emit_o      (emit),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  cse_ram #(
    .WIDTH(CNT_BITS),
    .DEPTH(NUM_BINS)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cse_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit),
    .ready_o       (emit_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

endmodule
